/* hdl/binomial_coefficient_top_defines.svh */
// Assertion macros shared by the binomial coefficient block.
`ifndef BINOMIAL_COEFFICIENT_TOP_DEFINES_SVH
`define BINOMIAL_COEFFICIENT_TOP_DEFINES_SVH

// Same-cycle implication, clocked on clk, held off during rst.
`define BINCO_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("binco check failed");

// Next-cycle implication, clocked on clk, held off during rst.
`define BINCO_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("binco check failed");

`endif

/* hdl/binco_pkg.sv */
package binco_pkg;

  parameter int DEFAULT_VALUE_WIDTH = 32;
  parameter int IN_WIDTH            = 32;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

endpackage

/* hdl/binco_alu.sv */
module binco_alu #(
  parameter int WIDTH = 33
) (
  input  logic [WIDTH-1:0]    a,
  input  logic [WIDTH-1:0]    b,
  input  binco_pkg::alu_op_t  op,
  output logic [WIDTH:0]      sum
);

  logic [WIDTH-1:0] b_eff;
  logic             cin;

  // Subtract as a + ~b + 1; top bit is carry, set when no borrow
  always_comb begin
    case (op)
      binco_pkg::ALU_SUB: begin
        b_eff = ~b;
        cin   = 1'b1;
      end
      default: begin
        b_eff = b;
        cin   = 1'b0;
      end
    endcase
  end

  assign sum = {1'b0, a} + {1'b0, b_eff} + {{WIDTH{1'b0}}, cin};

endmodule

/* hdl/binomial_coefficient_top.sv */
// Binomial coefficient C(n,k) by the multiplicative rule.
// Command channel: drive set_size (n) and subset_size (k) with start high; the
// transaction is taken at a rising edge where start is high and busy is low.
// busy stays high until the result is shown. The result channel presents
// coefficient and overflow for exactly one cycle with done high; the receiver
// cannot stall it, and busy falls in that same cycle so a new command may be
// taken at the edge that ends it.
// k > n gives 0; k = 0 or k = n gives 1. When C(n,k) does not fit in
// VALUE_WIDTH bits, coefficient is all ones and overflow is high.
// The sequencer runs R = min(k, n-k) rounds after a prep step; k > n is
// answered from the prep step, and an overflow ends the run in the round
// where it is found.
// Each round is a 32-step shift-add multiply followed by a (VALUE_WIDTH+32)-step
// restoring divide, both on the one shared adder/subtractor. One transaction
// is in flight at a time.
// Synchronous reset returns the sequencer to idle and clears done.
`include "binomial_coefficient_top_defines.svh"

module binomial_coefficient_top #(
  parameter int VALUE_WIDTH = binco_pkg::DEFAULT_VALUE_WIDTH
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [binco_pkg::IN_WIDTH-1:0]    set_size,
  input  logic [binco_pkg::IN_WIDTH-1:0]    subset_size,
  output logic                              done,
  output logic [VALUE_WIDTH-1:0]            coefficient,
  output logic                              overflow
);

  localparam int NW = binco_pkg::IN_WIDTH;
  localparam int PW = VALUE_WIDTH + NW;
  localparam int AW = (VALUE_WIDTH > NW + 1) ? VALUE_WIDTH : NW + 1;
  localparam int SW = $clog2(PW);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_CHECK,
    S_MUL,
    S_DIV,
    S_FIN
  } state_t;

  state_t                 state;
  logic [NW-1:0]          n;
  logic [NW-1:0]          k;
  logic [NW-1:0]          r;
  logic [NW-1:0]          i;
  logic [NW-1:0]          m;
  logic [VALUE_WIDTH-1:0] v;
  logic [PW-1:0]          prod;
  logic [NW-1:0]          rem;
  logic [SW-1:0]          cnt;

  logic [NW-1:0]          n_minus_k;
  logic [NW:0]            rem_sh;
  logic [VALUE_WIDTH:0]   mul_hi_next;
  logic                   no_borrow;
  binco_pkg::alu_op_t     alu_op;
  logic [AW-1:0]          alu_a;
  logic [AW-1:0]          alu_b;
  logic [AW:0]            alu_sum;

  binco_alu #(
    .WIDTH (AW)
  ) u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .op  (alu_op),
    .sum (alu_sum)
  );

  assign busy      = (state != S_IDLE);
  assign n_minus_k = n - k;
  assign rem_sh    = {rem, prod[PW-1]};
  assign no_borrow = alu_sum[AW];

  // Share one adder: accumulate in the multiply, trial subtract in the divide
  always_comb begin
    alu_op = binco_pkg::ALU_ADD;
    alu_a  = AW'(prod[PW-1:NW]);
    alu_b  = AW'(v);
    if (state == S_DIV) begin
      alu_op = binco_pkg::ALU_SUB;
      alu_a  = AW'(rem_sh);
      alu_b  = AW'(i);
    end
  end

  assign mul_hi_next = prod[0] ? alu_sum[VALUE_WIDTH:0] : {1'b0, prod[PW-1:NW]};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          done <= 1'b0;
          if (start) begin
            n     <= set_size;
            k     <= subset_size;
            state <= S_PREP;
          end
        end
        S_PREP: begin
          if (k > n) begin
            coefficient <= '0;
            overflow    <= 1'b0;
            done        <= 1'b1;
            state       <= S_IDLE;
          end else begin
            done  <= 1'b0;
            r     <= (k < n_minus_k) ? k : n_minus_k;
            v     <= VALUE_WIDTH'(1);
            i     <= NW'(1);
            m     <= n;
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (i > r) begin
            coefficient <= v;
            overflow    <= 1'b0;
            done        <= 1'b1;
            state       <= S_IDLE;
          end else begin
            done  <= 1'b0;
            prod  <= {{VALUE_WIDTH{1'b0}}, m};
            cnt   <= '0;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          // LSB-first shift-add: multiplier sits in the low half of prod
          done <= 1'b0;
          prod <= {mul_hi_next, prod[NW-1:1]};
          if (cnt == SW'(NW - 1)) begin
            rem   <= '0;
            cnt   <= '0;
            state <= S_DIV;
          end else begin
            cnt <= cnt + SW'(1);
          end
        end
        S_DIV: begin
          // Restoring divide by i; quotient bits shift in from the bottom
          done <= 1'b0;
          rem  <= no_borrow ? alu_sum[NW-1:0] : rem_sh[NW-1:0];
          prod <= {prod[PW-2:0], no_borrow};
          cnt  <= cnt + SW'(1);
          if (cnt == SW'(PW - 1)) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (|prod[PW-1:VALUE_WIDTH]) begin
            coefficient <= '1;
            overflow    <= 1'b1;
            done        <= 1'b1;
            state       <= S_IDLE;
          end else begin
            done  <= 1'b0;
            v     <= prod[VALUE_WIDTH-1:0];
            i     <= i + NW'(1);
            m     <= m - NW'(1);
            state <= S_CHECK;
          end
        end
        default: begin
          done  <= 1'b0;
          state <= S_IDLE;
        end
      endcase
    end
  end

  `BINCO_ASSERT_IMP(a_done_idle, done, !busy)
  `BINCO_ASSERT_IMP(a_ovf_sat, done && overflow, &coefficient)
  `BINCO_ASSERT_NXT(a_start_busy, start && !busy, busy)
  `BINCO_ASSERT_NXT(a_done_pulse, done, !done)

endmodule

/* tb/testbench.sv */
module testbench;

  localparam int W          = binco_pkg::DEFAULT_VALUE_WIDTH;
  localparam int IW         = binco_pkg::IN_WIDTH;
  localparam int N_RANDOM   = 540;
  localparam int TAIL_WAIT  = 2000;
  localparam int CYCLE_CAP  = 5_000_000;

  typedef struct packed {
    logic [W-1:0] coefficient;
    logic         overflow;
  } binomial_result_t;

  class binomial_scoreboard;
    binomial_result_t pending_results[$];
    int               mismatches;

    function new();
      mismatches = 0;
    endfunction

    // C(n,k) by the multiplicative rule, each round split as q*i + rm so that
    // no product exceeds 64 bits; stop at the first round that passes the limit
    function automatic binomial_result_t binomial(input bit [IW-1:0] n,
                                                  input bit [IW-1:0] k);
      longint unsigned  lim, nn, kk, r, i, v, m, q, rm, hi, lo;
      bit               ovf;
      binomial_result_t res;
      lim = 64'hFFFF_FFFF_FFFF_FFFF >> (64 - W);
      nn  = n;
      kk  = k;
      ovf = 1'b0;
      v   = 1;
      if (kk > nn) begin
        res.coefficient = '0;
        res.overflow    = 1'b0;
        return res;
      end
      r = (kk < nn - kk) ? kk : nn - kk;
      for (i = 1; i <= r && !ovf; i++) begin
        m  = nn - i + 1;
        q  = v / i;
        rm = v % i;
        if (q > lim / m) begin
          ovf = 1'b1;
        end else begin
          hi = q * m;
          lo = (rm * m) / i;
          if (hi > lim - lo) ovf = 1'b1;
          else v = hi + lo;
        end
      end
      if (ovf) v = lim;
      res.coefficient = v[W-1:0];
      res.overflow    = ovf;
      return res;
    endfunction

    function void note_command(input bit [IW-1:0] n, input bit [IW-1:0] k);
      pending_results.push_back(binomial(n, k));
    endfunction

    function void check_result(input logic [W-1:0] coef, input logic ovf);
      binomial_result_t want;
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0t: result with nothing pending: coefficient %h overflow %b",
                 $time, coef, ovf);
        return;
      end
      want = pending_results.pop_front();
      if (coef !== want.coefficient) begin
        mismatches++;
        $display("%0t: coefficient expected %h, got %h", $time,
                 want.coefficient, coef);
      end
      if (ovf !== want.overflow) begin
        mismatches++;
        $display("%0t: overflow expected %b, got %b", $time, want.overflow, ovf);
      end
    endfunction
  endclass

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          start = 1'b0;
  logic          busy;
  logic [IW-1:0] set_size = '0;
  logic [IW-1:0] subset_size = '0;
  logic          done;
  logic [W-1:0]  coefficient;
  logic          overflow;

  binomial_scoreboard board = new();
  longint unsigned    cycle_count = 0;

  binomial_coefficient_top u_top (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .set_size    (set_size),
    .subset_size (subset_size),
    .done        (done),
    .coefficient (coefficient),
    .overflow    (overflow)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_CAP) begin
      $display("%0t: run exceeded cycle limit", $time);
      $display("testbench: done, errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && done) board.check_result(coefficient, overflow);
  end

  // Hold start for the transaction, return once busy has fallen.
  task automatic send_command(input bit [IW-1:0] n, input bit [IW-1:0] k,
                              input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start       <= 1'b1;
    set_size    <= n;
    subset_size <= k;
    @(posedge clk);
    while (busy) @(posedge clk);
    board.note_command(n, k);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (board.pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic pick_command(output bit [IW-1:0] n, output bit [IW-1:0] k);
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 35) begin
      n = $urandom_range(0, 70);
      k = $urandom_range(0, n + 3);
    end else if (sel < 50) begin
      n = $urandom;
      k = $urandom_range(0, 1) ? $urandom_range(0, 4) : n - $urandom_range(0, 4);
    end else if (sel < 65) begin
      n = $urandom;
      k = $urandom;
    end else if (sel < 80) begin
      // near the middle of a row, where the value overflows late if at all
      n = $urandom_range(30, 68);
      k = (n >> 1) - 2 + $urandom_range(0, 4);
    end else if (sel < 90) begin
      n = $urandom_range(60000, 120000);
      k = $urandom_range(0, 1) ? $urandom_range(1, 3) : n - $urandom_range(1, 3);
    end else begin
      n = $urandom_range(0, 1000);
      k = $urandom_range(0, n);
    end
  endtask

  initial begin
    bit [IW-1:0] dir_n[] = '{0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                             32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 1, 4,
                             5, 33, 34, 35, 65536, 92682, 92683, 100,
                             32'hFFFF_FFFF, 32'h8000_0000, 67, 20};
    bit [IW-1:0] dir_k[] = '{0, 1, 32'hFFFF_FFFF, 0, 1,
                             32'hFFFF_FFFE, 2, 32'hFFFF_FFFF, 1, 2,
                             7, 16, 17, 17, 2, 2, 92681, 50,
                             32'h8000_0000, 32'h7FFF_FFFF, 33, 10};
    bit [IW-1:0] n, k;
    bit          burst;
    int          gap;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_n[j]) send_command(dir_n[j], dir_k[j], $urandom_range(0, 3));
    drain_results();

    burst = 1'b0;
    for (int j = 0; j < N_RANDOM; j++) begin
      // switch between back-to-back stretches and randomly gapped ones
      if (j % 30 == 0) burst = ($urandom_range(0, 3) == 0);
      if (j == N_RANDOM / 2) drain_results();
      gap = burst ? 0 : $urandom_range(0, 17);
      pick_command(n, k);
      send_command(n, k, gap);
    end

    start <= 1'b0;
    while (board.pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_WAIT) @(posedge clk);

    if (board.mismatches == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+hdl
hdl/binco_pkg.sv
hdl/binco_alu.sv
hdl/binomial_coefficient_top.sv
tb/testbench.sv
